// ===== hw/rtl/bba_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bba_pkg;

   // Default counter and limit width.
   localparam int COUNT_WIDTH_DEFAULT = 48;

   // Reset value of both limits before truncation to the counter width.
   localparam logic [63:0] LIMIT_RESET_VALUE = 64'd1073741824;

   // Configuration register indexes.
   localparam int CSR_INDEX_WIDTH = 2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TRACKED_LIMIT = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PENDING_LIMIT = 2'd1;

   // Request kinds.
   localparam logic REQ_RELEASE = 1'b1;

   // Category codes.
   localparam logic [1:0] CAT_PENDING = 2'd3;

   // Result status codes.
   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_TRACKED   = 2'd1,
      STATUS_PENDING   = 2'd2,
      STATUS_UNDERFLOW = 2'd3
   } status_type;

endpackage

`default_nettype wire

// ===== hw/rtl/byte_budget_accountant.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Byte budget accountant.
// Requests arrive on the req_ channel (valid/ready). Each beat reserves or
// releases an amount in one of four categories: session, module, input batch
// and pending output. Every request produces exactly one beat on the rsp_
// channel carrying a status, the selected counter and the saturating sum of
// the three tracked counters, both taken after the request.
// A request is captured in an input register, then evaluated and applied to
// the counters in a single pass into the result register, which raises
// rsp_valid; one request per cycle is sustained as long as rsp_ready stays
// high. The counters are read and written in that one pass, so back-to-back
// requests always see each other's effect. When the receiver stalls, the
// result register holds its beat and the input register still takes one
// more request; req_ready falls only when both are full. The user must write
// the two limits through the csr_ port only while idle; the block does not
// enforce it. Synchronous reset clears all counters and both pipeline stages
// and sets both limits to 2^30 (truncated to the counter width).
module byte_budget_accountant
   import bba_pkg::*;
#(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
   input  wire                        clock,
   input  wire                        reset,

   input  wire                        req_valid,
   output logic                       req_ready,
   input  wire                        req_type,
   input  wire  [1:0]                 req_category,
   input  wire  [COUNT_WIDTH-1:0]     req_amount,

   output logic                       rsp_valid,
   input  wire                        rsp_ready,
   output logic [1:0]                 rsp_status,
   output logic [COUNT_WIDTH-1:0]     rsp_category_total,
   output logic [COUNT_WIDTH-1:0]     rsp_tracked_total,

   input  wire                        csr_wen,
   input  wire  [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire  [COUNT_WIDTH-1:0]     csr_wdata
);

   localparam int W = COUNT_WIDTH;
   localparam logic [W-1:0] LIMIT_RESET = W'(LIMIT_RESET_VALUE);

   // Saturate the exact tracked sum to the counter width.
   function automatic logic [W-1:0] saturate(input logic [W+1:0] value);
      logic [W-1:0] result;
      if (value[W+1:W] != 2'd0) begin
         result = '1;
      end else begin
         result = value[W-1:0];
      end
      return result;
   endfunction

   // Limit registers.
   logic [W-1:0] tracked_limit_ff;
   logic [W-1:0] pending_limit_ff;

   // Counters and the exact (unsaturated) sum of the three tracked ones.
   logic [W-1:0] cnt_ff [4];
   logic [W-1:0] cnt_in [4];
   logic [W+1:0] sum_ff;
   logic [W+1:0] sum_in;

   // Input stage.
   logic         s1_valid_ff;
   logic         s1_type_ff;
   logic [1:0]   s1_cat_ff;
   logic [W-1:0] s1_amt_ff;

   // Result stage.
   logic         rsp_valid_ff;
   status_type   rsp_status_ff;
   status_type   status_in;
   logic [W-1:0] rsp_cat_total_ff;
   logic [W-1:0] rsp_cat_total_in;
   logic [W-1:0] rsp_tracked_total_ff;
   logic [W-1:0] rsp_tracked_total_in;

   // Evaluation signals.
   logic         s1_fire;
   logic         req_fire;
   logic [W-1:0] sel_cnt;
   logic [W-1:0] tracked_sat;
   logic         is_pending;
   logic [W-1:0] base_value;
   logic [W-1:0] limit_value;
   logic [W:0]   check_sum;
   logic         over_limit;
   logic         underflow;
   logic [W-1:0] new_cnt;
   logic         commit;

   // Handshake: the input stage moves on when the result register is free
   // or is being emptied this cycle.
   assign s1_fire   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_fire;
   assign req_fire  = req_valid && req_ready;

   // Evaluate the request in the input stage against the current counters.
   always_comb begin
      sel_cnt     = cnt_ff[s1_cat_ff];
      tracked_sat = saturate(sum_ff);
      is_pending  = (s1_cat_ff == CAT_PENDING);
      base_value  = is_pending ? sel_cnt : tracked_sat;
      limit_value = is_pending ? pending_limit_ff : tracked_limit_ff;
      check_sum   = {1'b0, base_value} + {1'b0, s1_amt_ff};
      over_limit  = check_sum > {1'b0, limit_value};
      underflow   = s1_amt_ff > sel_cnt;

      status_in = STATUS_OK;
      new_cnt   = sel_cnt;
      if (s1_type_ff == REQ_RELEASE) begin
         if (underflow) begin
            status_in = STATUS_UNDERFLOW;
         end else begin
            new_cnt = sel_cnt - s1_amt_ff;
         end
      end else if (over_limit) begin
         if (is_pending) begin
            status_in = STATUS_PENDING;
         end else begin
            status_in = STATUS_TRACKED;
         end
      end else begin
         new_cnt = sel_cnt + s1_amt_ff;
      end
      commit = (status_in == STATUS_OK);

      // The tracked sum follows only accepted changes to tracked counters.
      sum_in = sum_ff;
      if (s1_fire && commit && !is_pending) begin
         if (s1_type_ff == REQ_RELEASE) begin
            sum_in = sum_ff - {2'b00, s1_amt_ff};
         end else begin
            sum_in = sum_ff + {2'b00, s1_amt_ff};
         end
      end

      for (int i = 0; i < 4; i++) begin
         cnt_in[i] = cnt_ff[i];
      end
      if (s1_fire && commit) begin
         cnt_in[s1_cat_ff] = new_cnt;
      end

      rsp_cat_total_in     = new_cnt;
      rsp_tracked_total_in = saturate(sum_in);
   end

   // Configuration, counters and control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         tracked_limit_ff <= LIMIT_RESET;
         pending_limit_ff <= LIMIT_RESET;
         for (int i = 0; i < 4; i++) begin
            cnt_ff[i] <= '0;
         end
         sum_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wen) begin
            unique case (csr_index)
               CSR_TRACKED_LIMIT: tracked_limit_ff <= csr_wdata;
               CSR_PENDING_LIMIT: pending_limit_ff <= csr_wdata;
               default: ;
            endcase
         end
         for (int i = 0; i < 4; i++) begin
            cnt_ff[i] <= cnt_in[i];
         end
         sum_ff <= sum_in;
         if (req_fire) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_fire) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_type_ff <= req_type;
         s1_cat_ff  <= req_category;
         s1_amt_ff  <= req_amount;
      end
      if (s1_fire) begin
         rsp_status_ff        <= status_in;
         rsp_cat_total_ff     <= rsp_cat_total_in;
         rsp_tracked_total_ff <= rsp_tracked_total_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_category_total = rsp_cat_total_ff;
   assign rsp_tracked_total  = rsp_tracked_total_ff;

   // The exact sum always matches the three tracked counters.
   a_sum_matches: assert property (@(posedge clock) disable iff (reset)
      sum_ff == ({2'b00, cnt_ff[0]} + {2'b00, cnt_ff[1]} + {2'b00, cnt_ff[2]}))
      else $error("tracked sum out of step with counters");

   // A refused request leaves every counter unchanged.
   a_refused_stable: assert property (@(posedge clock) disable iff (reset)
      (s1_fire && !commit) |=> ($stable(sum_ff) && $stable(cnt_ff[0]) &&
         $stable(cnt_ff[1]) && $stable(cnt_ff[2]) && $stable(cnt_ff[3])))
      else $error("refused request changed a counter");

   // The reported tracked total is the saturated sum just written.
   a_tracked_total: assert property (@(posedge clock) disable iff (reset)
      s1_fire |=> (rsp_tracked_total == saturate(sum_ff)))
      else $error("tracked total does not match counters");

   // An empty result register never blocks the input.
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_ready)
      else $error("input stalled with empty result register");

endmodule

`default_nettype wire
